/* sv/xtea_pkg.sv */
// Package for the XTEA block cipher core: payload types, key type, round constants
// and the combinational half-round function. Depends on nothing else.
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int unsigned ROUNDS     = 32;
  localparam int unsigned NUM_STAGES = 2 * ROUNDS;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned KEY_IDX_W  = $clog2(KEY_WORDS);
  localparam int unsigned CNT_W      = $clog2(NUM_STAGES + 1);
  localparam logic [31:0] DELTA      = 32'h9E37_79B9;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] in_word0;
    logic [31:0] in_word1;
  } xtea_in_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
  } xtea_out_t;

  typedef logic [KEY_WORDS-1:0][31:0] xtea_key_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } xtea_ab_t;

  // Round sum after n steps of the delta, wrapped to 32 bits.
  function automatic logic [31:0] sum_at(int unsigned n);
    logic [63:0] prod;
    prod = 64'(DELTA) * 64'(n);
    return prod[31:0];
  endfunction

  function automatic logic [31:0] mix(logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // One half of a round. The sums are constants of the stage, so the key
  // selection folds to a fixed word.
  function automatic xtea_ab_t half_round(logic op, logic second, logic [31:0] sum_enc,
                                          logic [31:0] sum_dec, xtea_key_t key,
                                          xtea_ab_t ab);
    xtea_ab_t res;
    res = ab;
    if (op == OP_ENCRYPT) begin
      if (!second) begin
        res.a = ab.a + (mix(ab.b) ^ (sum_enc + key[sum_enc[1:0]]));
      end else begin
        res.b = ab.b + (mix(ab.a) ^ (sum_enc + key[sum_enc[12:11]]));
      end
    end else begin
      if (!second) begin
        res.b = ab.b - (mix(ab.a) ^ (sum_dec + key[sum_dec[12:11]]));
      end else begin
        res.a = ab.a - (mix(ab.b) ^ (sum_dec + key[sum_dec[1:0]]));
      end
    end
    return res;
  endfunction

endpackage

/* sv/xtea_block_cipher_core.sv */
// XTEA block cipher core: 64-bit blocks, 128-bit key, one half-round per pipeline stage.
// One block per cycle is sustained while the output is ready.
// Each of the 64 stages computes one half-round; the last stage is the output register.
// A stalled output holds its stage; empty stages upstream still fill, so no block is lost.
// Reset clears all stage valid bits and the four key words to zero.
// Depends on xtea_pkg.
`timescale 1ns / 1ps

module xtea_block_cipher_core
  import xtea_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  xtea_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output xtea_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [KEY_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  xtea_key_t             key_q;
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] v_d;
  logic [NUM_STAGES-1:0] op_q;
  xtea_ab_t              ab_q [NUM_STAGES];
  logic [NUM_STAGES:0]   move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // A stage loads when the last stage moves (the output drains or is empty) or when it is empty itself.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_move
    if (s == NUM_STAGES - 1) begin : g_last
      assign move[s] = out_ready_i || !v_q[s];
    end else begin : g_mid
      assign move[s] = move[NUM_STAGES-1] || !v_q[s];
    end
  end
  assign move[NUM_STAGES] = out_ready_i;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam int unsigned RND    = s / 2;
    localparam logic        SECOND = (s % 2) == 1;
    localparam logic [31:0] SUM_E  = sum_at(SECOND ? RND + 1 : RND);
    localparam logic [31:0] SUM_D  = sum_at(SECOND ? ROUNDS - RND - 1 : ROUNDS - RND);

    logic     src_v;
    logic     src_op;
    xtea_ab_t src_ab;
    xtea_ab_t ab_d;

    if (s == 0) begin : g_src_in
      assign src_v     = in_valid_i;
      assign src_op    = in_data_i.op;
      assign src_ab.a  = in_data_i.in_word0;
      assign src_ab.b  = in_data_i.in_word1;
    end else begin : g_src_prev
      assign src_v  = v_q[s-1];
      assign src_op = op_q[s-1];
      assign src_ab = ab_q[s-1];
    end

    always_comb begin
      ab_d   = half_round(src_op, SECOND, SUM_E, SUM_D, key_q, src_ab);
      v_d[s] = move[s] ? src_v : (v_q[s] && !move[s+1]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_d[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (move[s] && src_v) begin
        op_q[s] <= src_op;
        ab_q[s] <= ab_d;
      end
    end
  end

  assign in_ready_o           = move[0];
  assign out_valid_o          = v_q[NUM_STAGES-1];
  assign out_data_o.out_word0 = ab_q[NUM_STAGES-1].a;
  assign out_data_o.out_word1 = ab_q[NUM_STAGES-1].b;

endmodule

/* sv/xtea_chk.sv */
// Port-level checker for the XTEA block cipher core, bound to every instance of the core.
// Depends on xtea_pkg and xtea_block_cipher_core.
`timescale 1ns / 1ps

module xtea_chk
  import xtea_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input xtea_out_t            out_data_o
);

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The core holds no blocks once reset has been seen at a clock edge.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // A draining output frees every stage, so the input side must be open.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input not ready while output drains");

  // Every output transfer matches an earlier input transfer, within pipeline depth.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || cnt_q != '0) && cnt_q <= CNT_W'(NUM_STAGES))
    else $error("output without input or too many blocks in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

endmodule

bind xtea_block_cipher_core xtea_chk u_xtea_chk (.*);
